FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the collision time unit.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");
`else
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/hsc_pkg.sv
// Shared constants and types of the collision time unit.
// No dependencies; imported by every module of the block.
package hsc_pkg;

  localparam int NUM_PARTICLES = 1024;
  localparam int IDX_W         = 10;
  localparam int IDX_AW        = (NUM_PARTICLES > 2) ? $clog2(NUM_PARTICLES) : 1;
  localparam int TIME_W        = 32;
  localparam logic [TIME_W-1:0] TIME_NONE = '1;
  localparam int BOX_W         = 31;
  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;
  localparam int COORD_W       = 32;
  localparam int CMD_W         = 2;
  localparam int IN_TDATA_W    = 248;
  localparam int OUT_TDATA_W   = 48;

  // serial multiplier: one digit of the second operand per cycle
  localparam int MUL_W         = 64;
  localparam int MUL_DIGIT_W   = 4;
  localparam int MUL_STEPS     = MUL_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W     = $clog2(MUL_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

endpackage

FILE: hdl/hsc_mul.sv
// Digit-serial unsigned multiplier, 64 x 64 -> 128, one 4-bit digit per cycle.
// Depends on hsc_pkg.
module hsc_mul import hsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic                 done_o,
  output logic [2*MUL_W-1:0]   prod_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [MUL_CNT_W-1:0]         cnt_q;
  logic [MUL_W-1:0]             a_q;
  logic [2*MUL_W-1:0]           p_q;
  logic [MUL_W+MUL_DIGIT_W-1:0] sum;

  // add a times the low digit to the upper half, then shift one digit right
  assign sum = {{MUL_DIGIT_W{1'b0}}, p_q[2*MUL_W-1:MUL_W]} + (a_q * p_q[MUL_DIGIT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[MUL_W-1:MUL_DIGIT_W]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: hdl/hard_sphere_collision_time_update_unit.sv
// Top level of the pair collision time unit: sequencer, wrap, root, divide, table.
// Depends on hsc_pkg, hsc_mul and assert_macros.svh.
//
//  channel    | dir | handshake              | payload
//  -----------+-----+------------------------+--------------------------------------
//  s_axis     | in  | tvalid/tready          | tuser=cmd, tdata=indices, r, v, s2
//  m_axis     | out | tvalid/tready          | tuser=hit, tdata=time, partner
//  cfg        | in  | cfg_we_i (no wait)     | cfg_wdata_i = box_length
//
// After acceptance an evaluate transfer runs the minimum image remainder (three lanes in
// parallel), up to 11 products on the shared 4-bit digit multiplier, the square root and
// the Q16.16 divide, plus checks, the table update and the hand-off. Read, clear and pairs
// with equal indices skip the arithmetic. After reset a clearing pass fills every table
// entry; no item is taken. The result sits in an output register, so the next item enters
// while it waits.
`include "assert_macros.svh"
module hard_sphere_collision_time_update_unit import hsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [BOX_W-1:0]       cfg_wdata_i,    // box_length, unsigned Q15.16
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: first_index, second_index, rel_pos_x/y/z, rel_vel_x/y/z, contact_dist_sq
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_time, out_partner, zero pad
  output logic [0:0]             m_axis_tuser    // hit
);

  localparam int POS_LSB = 2 * IDX_W;
  localparam int VEL_LSB = POS_LSB + 3 * COORD_W;
  localparam int S2_LSB  = VEL_LSB + 3 * COORD_W;
  localparam int MEM_W   = IDX_W + TIME_W;
  localparam int DVD_W   = 2 * COORD_W + 16;

  typedef enum logic [18:0] {
    ST_INIT = 19'b0000000000000000001,
    ST_IDLE = 19'b0000000000000000010,
    ST_WRAP = 19'b0000000000000000100,
    ST_FOLD = 19'b0000000000000001000,
    ST_MULS = 19'b0000000000000010000,
    ST_MULW = 19'b0000000000000100000,
    ST_CHK  = 19'b0000000000001000000,
    ST_DISC = 19'b0000000000010000000,
    ST_SQRT = 19'b0000000000100000000,
    ST_ROOT = 19'b0000000001000000000,
    ST_DIV  = 19'b0000000010000000000,
    ST_RDI  = 19'b0000000100000000000,
    ST_UPDI = 19'b0000001000000000000,
    ST_RDJ  = 19'b0000010000000000000,
    ST_UPDJ = 19'b0000100000000000000,
    ST_CLR  = 19'b0001000000000000000,
    ST_RDA  = 19'b0010000000000000000,
    ST_RDD  = 19'b0100000000000000000,
    ST_OUT  = 19'b1000000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [BOX_W-1:0]    box_q;
  logic [COORD_W-1:0]  len;

  logic [IDX_AW-1:0]   init_cnt_q, init_cnt_d;
  logic [6:0]          cnt_q, cnt_d;
  logic [3:0]          pidx_q, pidx_d;

  logic [IDX_W-1:0]    idx_i_q, idx_i_d, idx_j_q, idx_j_d;
  logic [COORD_W-1:0]  s2_q, s2_d;

  // minimum image lanes
  logic [COORD_W-1:0]  wsh_q [3], wsh_d [3];
  logic [COORD_W-1:0]  wrem_q [3], wrem_d [3];
  logic                wneg_q [3], wneg_d [3];
  logic [COORD_W-2:0]  rmag_q [3], rmag_d [3];
  logic                rsgn_q [3], rsgn_d [3];
  logic [COORD_W-1:0]  vmag_q [3], vmag_d [3];
  logic                vsgn_q [3], vsgn_d [3];
  logic [COORD_W-1:0]  in_pos [3], in_vel [3];
  logic [COORD_W:0]    wtrial [3];
  logic [COORD_W-1:0]  fold_r0 [3];
  logic                fold_big [3];

  // quadratic terms
  logic [MUL_W+1:0]    b_q, b_d;          // two's complement r.v
  logic [MUL_W-1:0]    rr_q, rr_d, vv_q, vv_d;
  logic [MUL_W-1:0]    babs_q, babs_d, dmag_q, dmag_d;
  logic                dneg_q, dneg_d;
  logic [2*MUL_W-1:0]  b2_q, b2_d, disc_q, disc_d;
  logic [MUL_W+1:0]    dwide;

  // root and divide
  logic [MUL_W:0]      srem_q, srem_d;
  logic [MUL_W-1:0]    sres_q, sres_d;
  logic [MUL_W+2:0]    sshift, strial;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic [MUL_W-1:0]    drem_q, drem_d;
  logic [MUL_W:0]      dtrial;
  logic                dge;
  logic [TIME_W-1:0]   quo_q, quo_d;
  logic                sat_q, sat_d;

  // result and output register
  logic                res_hit_q, res_hit_d;
  logic [TIME_W-1:0]   res_time_q, res_time_d;
  logic [IDX_W-1:0]    res_part_q, res_part_d;
  logic                out_vld_q, out_vld_d;
  logic                out_hit_q, out_hit_d;
  logic [TIME_W-1:0]   out_time_q, out_time_d;
  logic [IDX_W-1:0]    out_part_q, out_part_d;

  // multiplier
  logic                mul_start, mul_done;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_prod;

  // entry table: partner in the upper bits, time in the lower
  logic [MEM_W-1:0]    mem_q [NUM_PARTICLES];
  logic                mem_we;
  logic [IDX_AW-1:0]   mem_waddr, mem_raddr;
  logic [MEM_W-1:0]    mem_wdata, rdata_q;
  logic [TIME_W-1:0]   rd_time;
  logic                vi, vj, in_xfer;

  assign len     = (box_q == '0) ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, box_q};
  assign vi      = int'(idx_i_q) < NUM_PARTICLES;
  assign vj      = int'(idx_j_q) < NUM_PARTICLES;
  assign rd_time = rdata_q[TIME_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  hsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // lane datapath pieces
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pos[k]   = s_axis_tdata[POS_LSB + k*COORD_W +: COORD_W];
      in_vel[k]   = s_axis_tdata[VEL_LSB + k*COORD_W +: COORD_W];
      wtrial[k]   = {wrem_q[k], wsh_q[k][COORD_W-1]};
      fold_r0[k]  = (wneg_q[k] && wrem_q[k] != '0) ? len - wrem_q[k] : wrem_q[k];
      fold_big[k] = {fold_r0[k], 1'b0} > {1'b0, len};
    end
  end

  // multiplier operands by product number
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (pidx_q)
      4'd0:    begin mul_a = MUL_W'(rmag_q[0]); mul_b = MUL_W'(vmag_q[0]); end
      4'd1:    begin mul_a = MUL_W'(rmag_q[1]); mul_b = MUL_W'(vmag_q[1]); end
      4'd2:    begin mul_a = MUL_W'(rmag_q[2]); mul_b = MUL_W'(vmag_q[2]); end
      4'd3:    begin mul_a = MUL_W'(rmag_q[0]); mul_b = MUL_W'(rmag_q[0]); end
      4'd4:    begin mul_a = MUL_W'(rmag_q[1]); mul_b = MUL_W'(rmag_q[1]); end
      4'd5:    begin mul_a = MUL_W'(rmag_q[2]); mul_b = MUL_W'(rmag_q[2]); end
      4'd6:    begin mul_a = MUL_W'(vmag_q[0]); mul_b = MUL_W'(vmag_q[0]); end
      4'd7:    begin mul_a = MUL_W'(vmag_q[1]); mul_b = MUL_W'(vmag_q[1]); end
      4'd8:    begin mul_a = MUL_W'(vmag_q[2]); mul_b = MUL_W'(vmag_q[2]); end
      4'd9:    begin mul_a = babs_q;            mul_b = babs_q;            end
      default: begin mul_a = vv_q;              mul_b = dmag_q;            end
    endcase
  end

  assign sshift = {srem_q, disc_q[2*MUL_W-1 -: 2]} ;
  assign strial = {1'b0, sres_q, 2'b01};
  assign dtrial = {drem_q, dvd_q[DVD_W-1]};
  assign dge    = dtrial >= {1'b0, vv_q};
  assign dwide  = {2'b00, rr_q} - {{(MUL_W-COORD_W-14){1'b0}}, s2_q, 16'h0000};

  // sequencer
  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    cnt_d      = cnt_q;
    pidx_d     = pidx_q;
    idx_i_d    = idx_i_q;
    idx_j_d    = idx_j_q;
    s2_d       = s2_q;
    wsh_d      = wsh_q;
    wrem_d     = wrem_q;
    wneg_d     = wneg_q;
    rmag_d     = rmag_q;
    rsgn_d     = rsgn_q;
    vmag_d     = vmag_q;
    vsgn_d     = vsgn_q;
    b_d        = b_q;
    rr_d       = rr_q;
    vv_d       = vv_q;
    babs_d     = babs_q;
    dmag_d     = dmag_q;
    dneg_d     = dneg_q;
    b2_d       = b2_q;
    disc_d     = disc_q;
    srem_d     = srem_q;
    sres_d     = sres_q;
    dvd_d      = dvd_q;
    drem_d     = drem_q;
    quo_d      = quo_q;
    sat_d      = sat_q;
    res_hit_d  = res_hit_q;
    res_time_d = res_time_q;
    res_part_d = res_part_q;
    mul_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = IDX_AW'(idx_i_q);
    mem_wdata  = {{IDX_W{1'b0}}, TIME_NONE};
    mem_raddr  = IDX_AW'(idx_i_q);

    unique case (state_q)
      ST_INIT: begin
        // clearing pass: one entry per cycle
        mem_we     = 1'b1;
        mem_waddr  = init_cnt_q;
        init_cnt_d = init_cnt_q + 1'b1;
        if (int'(init_cnt_q) == NUM_PARTICLES - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          idx_i_d = s_axis_tdata[IDX_W-1:0];
          idx_j_d = s_axis_tdata[2*IDX_W-1:IDX_W];
          s2_d    = s_axis_tdata[S2_LSB +: COORD_W];
          unique case (s_axis_tuser)
            CMD_EVAL: begin
              if (s_axis_tdata[IDX_W-1:0] == s_axis_tdata[2*IDX_W-1:IDX_W]) begin
                res_hit_d  = 1'b0;
                res_time_d = TIME_NONE;
                res_part_d = '0;
                state_d    = ST_OUT;
              end else begin
                for (int k = 0; k < 3; k++) begin
                  wneg_d[k] = in_pos[k][COORD_W-1];
                  wsh_d[k]  = in_pos[k][COORD_W-1] ? -in_pos[k] : in_pos[k];
                  wrem_d[k] = '0;
                  vsgn_d[k] = in_vel[k][COORD_W-1];
                  vmag_d[k] = in_vel[k][COORD_W-1] ? -in_vel[k] : in_vel[k];
                end
                b_d     = '0;
                rr_d    = '0;
                vv_d    = '0;
                cnt_d   = '0;
                state_d = ST_WRAP;
              end
            end
            CMD_CLEAR: state_d = ST_CLR;
            CMD_READ:  state_d = ST_RDA;
            default: begin
              res_hit_d  = 1'b0;
              res_time_d = '0;
              res_part_d = '0;
              state_d    = ST_OUT;
            end
          endcase
        end
      end
      ST_WRAP: begin
        // restoring remainder of |x| by the box length, one bit per cycle
        for (int k = 0; k < 3; k++) begin
          wsh_d[k]  = {wsh_q[k][COORD_W-2:0], 1'b0};
          wrem_d[k] = (wtrial[k] >= {1'b0, len}) ? COORD_W'(wtrial[k] - {1'b0, len})
                                                 : COORD_W'(wtrial[k]);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'(COORD_W - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int k = 0; k < 3; k++) begin
          rsgn_d[k] = fold_big[k];
          rmag_d[k] = fold_big[k] ? (COORD_W-1)'(len - fold_r0[k])
                                  : (COORD_W-1)'(fold_r0[k]);
        end
        pidx_d  = '0;
        state_d = ST_MULS;
      end
      ST_MULS: begin
        mul_start = 1'b1;
        state_d   = ST_MULW;
      end
      ST_MULW: begin
        if (mul_done) begin
          pidx_d  = pidx_q + 1'b1;
          state_d = ST_MULS;
          case (pidx_q)
            4'd0, 4'd1, 4'd2: begin
              if (rsgn_q[pidx_q[1:0]] ^ vsgn_q[pidx_q[1:0]]) begin
                b_d = b_q - {2'b00, mul_prod[MUL_W-1:0]};
              end else begin
                b_d = b_q + {2'b00, mul_prod[MUL_W-1:0]};
              end
            end
            4'd3, 4'd4, 4'd5: rr_d = rr_q + mul_prod[MUL_W-1:0];
            4'd6, 4'd7:       vv_d = vv_q + mul_prod[MUL_W-1:0];
            4'd8: begin
              vv_d    = vv_q + mul_prod[MUL_W-1:0];
              state_d = ST_CHK;
            end
            4'd9:   b2_d = mul_prod;
            default: begin
              disc_d  = mul_prod;
              state_d = ST_DISC;
            end
          endcase
        end
      end
      ST_CHK: begin
        // only an approaching pair can collide
        if (!b_q[MUL_W+1]) begin
          res_hit_d  = 1'b0;
          res_time_d = TIME_NONE;
          res_part_d = '0;
          state_d    = ST_OUT;
        end else begin
          babs_d  = MUL_W'(-b_q);
          dneg_d  = dwide[MUL_W+1];
          dmag_d  = dwide[MUL_W+1] ? MUL_W'(-dwide) : MUL_W'(dwide);
          pidx_d  = 4'd9;
          state_d = ST_MULS;
        end
      end
      ST_DISC: begin
        srem_d = '0;
        sres_d = '0;
        cnt_d  = '0;
        if (dneg_q) begin
          disc_d  = b2_q + disc_q;
          state_d = ST_SQRT;
        end else if (disc_q >= b2_q) begin
          res_hit_d  = 1'b0;
          res_time_d = TIME_NONE;
          res_part_d = '0;
          state_d    = ST_OUT;
        end else begin
          disc_d  = b2_q - disc_q;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root bit per cycle from two discriminant bits
        disc_d = {disc_q[2*MUL_W-3:0], 2'b00};
        if (sshift >= strial) begin
          srem_d = (MUL_W+1)'(sshift - strial);
          sres_d = {sres_q[MUL_W-2:0], 1'b1};
        end else begin
          srem_d = (MUL_W+1)'(sshift);
          sres_d = {sres_q[MUL_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'(MUL_W - 1)) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        res_hit_d  = 1'b1;
        res_part_d = '0;
        if (sres_q >= babs_q) begin
          // overlapping pair
          res_time_d = '0;
          state_d    = ST_RDI;
        end else begin
          dvd_d   = {babs_q - sres_q, 16'h0000};
          drem_d  = '0;
          quo_d   = '0;
          sat_d   = 1'b0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide; a one above the low 32 quotient bits saturates
        dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
        drem_d = dge ? MUL_W'(dtrial - {1'b0, vv_q}) : MUL_W'(dtrial);
        quo_d  = {quo_q[TIME_W-2:0], dge};
        if (dge && cnt_q < 7'(DVD_W - TIME_W)) begin
          sat_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'(DVD_W - 1)) begin
          res_time_d = sat_d ? TIME_NONE : quo_d;
          state_d    = ST_RDI;
        end
      end
      ST_RDI: begin
        mem_raddr = IDX_AW'(idx_i_q);
        state_d   = ST_UPDI;
      end
      ST_UPDI: begin
        mem_waddr = IDX_AW'(idx_i_q);
        mem_wdata = {idx_j_q, res_time_q};
        mem_we    = vi && (res_time_q < rd_time);
        state_d   = ST_RDJ;
      end
      ST_RDJ: begin
        mem_raddr = IDX_AW'(idx_j_q);
        state_d   = ST_UPDJ;
      end
      ST_UPDJ: begin
        mem_waddr = IDX_AW'(idx_j_q);
        mem_wdata = {idx_i_q, res_time_q};
        mem_we    = vj && (res_time_q < rd_time);
        state_d   = ST_OUT;
      end
      ST_CLR: begin
        mem_we     = vi;
        res_hit_d  = 1'b0;
        res_time_d = '0;
        res_part_d = '0;
        state_d    = ST_OUT;
      end
      ST_RDA: begin
        mem_raddr = IDX_AW'(idx_i_q);
        state_d   = ST_RDD;
      end
      ST_RDD: begin
        res_hit_d  = 1'b0;
        res_time_d = vi ? rd_time : TIME_NONE;
        res_part_d = vi ? rdata_q[MEM_W-1:TIME_W] : '0;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_hit_d  = out_hit_q;
    out_time_d = out_time_q;
    out_part_d = out_part_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (state_q == ST_OUT && (!out_vld_q || m_axis_tready)) begin
      out_vld_d  = 1'b1;
      out_hit_d  = res_hit_q;
      out_time_d = res_time_q;
      out_part_d = res_part_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_cnt_q <= '0;
      box_q      <= BOX_RESET;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
      pidx_q     <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
      pidx_q     <= pidx_d;
      if (cfg_we_i) begin
        box_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_i_q    <= idx_i_d;
    idx_j_q    <= idx_j_d;
    s2_q       <= s2_d;
    wsh_q      <= wsh_d;
    wrem_q     <= wrem_d;
    wneg_q     <= wneg_d;
    rmag_q     <= rmag_d;
    rsgn_q     <= rsgn_d;
    vmag_q     <= vmag_d;
    vsgn_q     <= vsgn_d;
    b_q        <= b_d;
    rr_q       <= rr_d;
    vv_q       <= vv_d;
    babs_q     <= babs_d;
    dmag_q     <= dmag_d;
    dneg_q     <= dneg_d;
    b2_q       <= b2_d;
    disc_q     <= disc_d;
    srem_q     <= srem_d;
    sres_q     <= sres_d;
    dvd_q      <= dvd_d;
    drem_q     <= drem_d;
    quo_q      <= quo_d;
    sat_q      <= sat_d;
    res_hit_q  <= res_hit_d;
    res_time_q <= res_time_d;
    res_part_q <= res_part_d;
    out_hit_q  <= out_hit_d;
    out_time_q <= out_time_d;
    out_part_q <= out_part_d;
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-TIME_W-IDX_W){1'b0}}, out_part_q, out_time_q};

  `ASSERT_IMPLIES(a_mul_done_in_wait, clk_i, rst_ni, mul_done, state_q == ST_MULW)
  `ASSERT_IMPLIES(a_update_only_earlier, clk_i, rst_ni,
                  mem_we && (state_q == ST_UPDI || state_q == ST_UPDJ), res_time_q < rd_time)
  `ASSERT_NEXT(a_out_loaded, clk_i, rst_ni,
               state_q == ST_OUT && (!out_vld_q || m_axis_tready), m_axis_tvalid)

endmodule

FILE: test/hard_sphere_collision_time_update_unit_tb.sv
// Self-checking bench for the pair collision time unit: directed table, then random traffic.
// Depends on hsc_pkg and the top level; predicts each result with its own table model or a typed row.
module hard_sphere_collision_time_update_unit_tb import hsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ONE         = 32'h0001_0000;
  localparam int          LIMIT       = 4_000_000;
  localparam int          HOLD_CYCLES = 3000;
  localparam int          DRAIN_WAIT  = 400;

  typedef struct {
    cmd_e                   cmd;
    logic [IDX_W-1:0]       fi;
    logic [IDX_W-1:0]       si;
    logic signed [31:0]     rp [3];
    logic signed [31:0]     rv [3];
    logic [31:0]            s2;
  } pair_item_t;

  typedef struct {
    logic              hit;
    logic [TIME_W-1:0] tm;
    logic [IDX_W-1:0]  partner;
  } pair_result_t;

  typedef struct {
    pair_item_t   it;
    bit           typed;
    pair_result_t res;
  } table_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [BOX_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  hard_sphere_collision_time_update_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the collision table and the box register
  logic [TIME_W-1:0] soonest_time [NUM_PARTICLES];
  logic [IDX_W-1:0]  soonest_partner [NUM_PARTICLES];
  logic [BOX_W-1:0]  box_shadow;

  pair_result_t pending_results [$];
  int  mismatches, n_seen, n_hits, n_evals, n_reads, n_clears;
  bit  calm;        // no idling on either side
  int  hold_reqs;   // long receiver hold-offs asked for
  int  holds_done;  // long receiver hold-offs carried out
  longint cycles;

  // Minimum image of one component into (-L/2, L/2].
  function automatic longint wrap_min_image(longint x, longint len);
    longint r;
    r = x % len;
    if (r < 0) r += len;
    if (2 * r > len) r -= len;
    return r;
  endfunction

  // Pair collision time in Q16.16; returns 1 when the pair collides.
  function automatic bit collision_time(pair_item_t it, output logic [31:0] t);
    longint           len, r, v, b, rr, d;
    logic [63:0]      vv, babs, root, cand, du;
    logic [127:0]     b2, prod, disc, q;
    len = (box_shadow == '0) ? 64'h8000_0000 : longint'({33'b0, box_shadow});
    b = 0; rr = 0; vv = '0; t = '1;
    for (int k = 0; k < 3; k++) begin
      r = wrap_min_image(longint'(it.rp[k]), len);
      v = longint'(it.rv[k]);
      b += r * v;
      rr += r * r;
      vv += 64'(v * v);
    end
    if (b >= 0) return 1'b0;
    babs = 64'(-b);
    b2 = 128'(babs) * 128'(babs);
    d = rr - (longint'({32'b0, it.s2}) << 16);
    if (d >= 0) begin
      du = 64'(d);
      prod = 128'(vv) * 128'(du);
      if (prod >= b2) return 1'b0;
      disc = b2 - prod;
    end else begin
      du = 64'(-d);
      disc = b2 + 128'(vv) * 128'(du);
    end
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= disc) root = cand;
    end
    if (root >= babs) begin
      t = '0;
      return 1'b1;
    end
    q = (128'(babs - root) << 16) / 128'(vv);
    t = (q >= 128'h1_0000_0000) ? '1 : q[31:0];
    return 1'b1;
  endfunction

  // Advance the shadow table by one transfer and return the result it must produce.
  function automatic pair_result_t table_update(pair_item_t it);
    pair_result_t res;
    logic [31:0]  t;
    res = '{hit: 1'b0, tm: '0, partner: '0};
    case (it.cmd)
      CMD_EVAL: begin
        res.tm = TIME_NONE;
        if (it.fi != it.si && collision_time(it, t)) begin
          res.hit = 1'b1;
          res.tm = t;
          if (t < soonest_time[it.fi]) begin
            soonest_time[it.fi] = t;
            soonest_partner[it.fi] = it.si;
          end
          if (t < soonest_time[it.si]) begin
            soonest_time[it.si] = t;
            soonest_partner[it.si] = it.fi;
          end
        end
      end
      CMD_CLEAR: begin
        soonest_time[it.fi] = TIME_NONE;
        soonest_partner[it.fi] = '0;
      end
      CMD_READ: begin
        res.tm = soonest_time[it.fi];
        res.partner = soonest_partner[it.fi];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic table_row_t row(cmd_e c, int i, int j, logic [31:0] px, logic [31:0] py,
                                     logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                     logic [31:0] vz, logic [31:0] s2, bit typed = 0,
                                     logic hit = 0, logic [31:0] tm = 0, int pt = 0);
    table_row_t r;
    r.it.cmd = c;
    r.it.fi = i[IDX_W-1:0];
    r.it.si = j[IDX_W-1:0];
    r.it.rp[0] = px; r.it.rp[1] = py; r.it.rp[2] = pz;
    r.it.rv[0] = vx; r.it.rv[1] = vy; r.it.rv[2] = vz;
    r.it.s2 = s2;
    r.typed = typed;
    r.res = '{hit: hit, tm: tm, partner: pt[IDX_W-1:0]};
    return r;
  endfunction

  // Drive one transfer, wait for acceptance and record what must come back.
  task automatic offer(pair_item_t it, bit typed = 0, pair_result_t typed_res = '{0, 0, 0});
    pair_result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {4'b0, it.s2, it.rv[2], it.rv[1], it.rv[0],
                      it.rp[2], it.rp[1], it.rp[0], it.si, it.fi};
    do @(posedge clk_i); while (!s_axis_tready);
    res = table_update(it);
    pending_results.push_back(typed ? typed_res : res);
    case (it.cmd)
      CMD_EVAL:  n_evals++;
      CMD_CLEAR: n_clears++;
      default:   n_reads++;
    endcase
    // idle gap after the transfer, else keep tvalid high for the next one
    if (!calm && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_box(logic [BOX_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    box_shadow = val;
  endtask

  function automatic int pick_index();
    return ($urandom_range(0, 99) < 60) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
  endfunction

  // Mostly approaching pairs near contact; the rest is raw noise, reads and clears.
  function automatic pair_item_t random_item();
    pair_item_t it;
    longint     len, mag, r, rr, s2;
    int         roll, sh;
    roll = $urandom_range(0, 99);
    it.fi = IDX_W'(pick_index());
    it.si = ($urandom_range(0, 19) == 0) ? it.fi : IDX_W'(pick_index());
    it.cmd = (roll < 12) ? CMD_READ : (roll < 17) ? CMD_CLEAR : CMD_EVAL;
    for (int k = 0; k < 3; k++) begin
      it.rp[k] = $urandom;
      it.rv[k] = $urandom;
    end
    it.s2 = $urandom;
    if (roll >= 27) begin
      len = (box_shadow == '0) ? 64'h8000_0000 : longint'({33'b0, box_shadow});
      mag = longint'(1) << $urandom_range(6, 30);
      if (mag > len / 2) mag = len / 2;
      sh = $urandom_range(0, 6);
      rr = 0;
      for (int k = 0; k < 3; k++) begin
        r = longint'($urandom_range(0, 32'(2 * mag))) - mag;
        rr += r * r;
        it.rv[k] = 32'(-(r >>> sh) + longint'($urandom_range(0, 1 << $urandom_range(0, 16))));
        if ($urandom_range(0, 3) == 0) r += len * (longint'($urandom_range(0, 4)) - 2);
        it.rp[k] = 32'(r);
      end
      s2 = ((rr >> 16) * longint'($urandom_range(0, 1100))) / 1000;
      it.s2 = (s2 > 64'hFFFF_FFFF) ? '1 : 32'(s2);
    end
    return it;
  endfunction

  // Receiver: random stalls, calm stretches and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pair_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit %0b time %h partner %0d",
                   m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[41:32]);
      end else begin
        want = pending_results.pop_front();
        if (want.hit) n_hits++;
        if (want.hit !== m_axis_tuser[0] || want.tm !== m_axis_tdata[31:0] ||
            want.partner !== m_axis_tdata[41:32]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected hit %0b time %h partner %0d, got %0b %h %0d",
                     n_seen, want.hit, want.tm, want.partner,
                     m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[41:32]);
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    table_row_t directed [$];
    logic [BOX_W-1:0] boxes [4];
    int counts [4];
    for (int n = 0; n < NUM_PARTICLES; n++) begin
      soonest_time[n] = TIME_NONE;
      soonest_partner[n] = '0;
    end
    box_shadow = BOX_RESET;
    // fresh entries, equal indices, still and receding pairs, no real root, clear
    directed.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_EVAL, 3, 3, 26214, 0, 0, -ONE, 0, 0, 655, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_EVAL, 1, 2, 26214, 0, 0, 0, 0, 0, 655, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_EVAL, 1, 2, 26214, 0, 0, -ONE, 0, 0, 655));
    directed.push_back(row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    // overlapping pair collides at time zero
    directed.push_back(row(CMD_EVAL, 1, 5, 32768, 0, 0, -ONE, 0, 0, ONE, 1, 1, 0, 0));
    directed.push_back(row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // crawling pair, extreme and wrapped inputs
    directed.push_back(row(CMD_EVAL, 4, 6, 26214, 0, 0, -1, 0, 0, 0));
    directed.push_back(row(CMD_EVAL, 7, 8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(row(CMD_EVAL, 1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    directed.push_back(row(CMD_EVAL, 0, 1023, 26214 + 3 * ONE, 0, 0, -ONE, 0, 0, 655));
    directed.push_back(row(CMD_EVAL, 9, 10, 26214, 0, 0, ONE, 0, 0, 655, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_EVAL, 9, 10, 32768, 32768, 0, -ONE, 0, 0, 655,
                           1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_CLEAR, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, TIME_NONE, 0));
    directed.push_back(row(CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(CMD_EVAL, 2, 1, 13107, 0, 0, -ONE, 0, 0, 655));
    directed.push_back(row(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[n]) offer(directed[n].it, directed[n].typed, directed[n].res);
    wait_drained();

    boxes  = '{BOX_RESET, 31'd1, 31'h7FFF_FFFF, 31'($urandom_range(1, 32'h7FFF_FFFF))};
    counts = '{1000, 60, 400, 470};
    for (int ph = 0; ph < 4; ph++) begin
      write_box(boxes[ph]);
      for (int n = 0; n < counts[ph]; n++) begin
        calm = (ph == 0 && n >= 300 && n < 700);
        if (ph == 0 && n == 150) hold_reqs++;
        offer(random_item());
      end
      calm = 1'b0;
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d evaluations (%0d hits), %0d reads, %0d clears over 4 box lengths",
             n_evals, n_hits, n_reads, n_clears);
    $display("%0d results checked, %0d mismatches, %0d cycles", n_seen, mismatches, cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
